FILE: design/cbps_pkg.sv
// Shared types and constants for the cubic Bezier point sampler.
// No dependencies; every other file of the block imports this package.
package cbps_pkg;

    localparam int MAX_STEPS_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    // Width of the step count field and of the point index.
    localparam int CNT_BITS = 7;
    // s^3 and every Bernstein weight fit in three count widths.
    localparam int DEN_BITS = 3 * CNT_BITS;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture control points and clamped count
        logic       den_sq;     // s*s
        logic       den_cube;   // s*s*s
        logic       wgt_sq;     // (s-i)^2 and i^2
        logic       wgt_cube;   // the four cubic weights
        logic       acc_clr;    // clear product and accumulator registers
        logic       mul_en;     // register weight times coordinate
        logic       add_en;     // add registered product into accumulator
        logic [1:0] sel;        // control point taken by the multiplier
        logic       div_init;   // load divider from accumulator
        logic       div_step;   // one quotient bit
        logic       out_load;   // move finished point into output register
        logic       idx_inc;    // advance to next point
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic s_zero;    // clamped count is zero
        logic last;      // current point is the final one of the run
        logic out_free;  // output register can take a point this cycle
    } stat_t;

endpackage

FILE: design/cbps_ctrl.sv
// Controller of the cubic Bezier point sampler: sequences weight, MAC and
// divide steps per point. Depends on cbps_pkg.
module cbps_ctrl #(
    parameter int COORD_BITS = cbps_pkg::COORD_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output cbps_pkg::cmd_t  cmd,
    input  cbps_pkg::stat_t stat
);
    import cbps_pkg::*;

    localparam int NUM_BITS = DEN_BITS + COORD_BITS;
    localparam int DIV_CW   = $clog2(NUM_BITS);

    typedef enum logic [3:0] {
        IDLE, DEN_SQ, DEN_CUBE, WGT_SQ, WGT_CUBE, MAC, DIV_INIT, DIV, OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          mac_reg, mac_next;
    logic [DIV_CW-1:0]   div_reg, div_next;

    always_comb
    begin
        state_next = state_reg;
        mac_next   = mac_reg;
        div_next   = div_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = DEN_SQ;
                end
            end
            DEN_SQ:
            begin
                cmd.den_sq = 1'b1;
                state_next = stat.s_zero ? IDLE : DEN_CUBE;
            end
            DEN_CUBE:
            begin
                cmd.den_cube = 1'b1;
                state_next   = WGT_SQ;
            end
            WGT_SQ:
            begin
                cmd.wgt_sq = 1'b1;
                state_next = WGT_CUBE;
            end
            WGT_CUBE:
            begin
                cmd.wgt_cube = 1'b1;
                cmd.acc_clr  = 1'b1;
                mac_next     = '0;
                state_next   = MAC;
            end
            MAC:
            begin
                // four products, the last one added in the cycle after its product is registered
                cmd.mul_en = (mac_reg != 3'd4);
                cmd.add_en = 1'b1;
                cmd.sel    = mac_reg[1:0];
                mac_next   = mac_reg + 3'd1;
                if (mac_reg == 3'd4)
                begin
                    state_next = DIV_INIT;
                end
            end
            DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_next     = '0;
                state_next   = DIV;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                div_next     = div_reg + 1'b1;
                if (div_reg == DIV_CW'(NUM_BITS - 1))
                begin
                    state_next = OUT;
                end
            end
            OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.last)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = WGT_SQ;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            mac_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mac_reg   <= mac_next;
            div_reg   <= div_next;
        end
    end

endmodule

FILE: design/cbps_dpath.sv
// Datapath of the cubic Bezier point sampler: weights, x/y MAC lanes,
// bit-serial dividers and the output register. Depends on cbps_pkg.
module cbps_dpath #(
    parameter int MAX_STEPS  = cbps_pkg::MAX_STEPS_DEF,
    parameter int COORD_BITS = cbps_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cbps_pkg::cmd_t                   cmd,
    output cbps_pkg::stat_t                  stat,
    input  logic signed [COORD_BITS-1:0]     in_x [4],
    input  logic signed [COORD_BITS-1:0]     in_y [4],
    input  logic [cbps_pkg::CNT_BITS-1:0]    in_cnt,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [COORD_BITS-1:0]     out_x,
    output logic signed [COORD_BITS-1:0]     out_y,
    output logic                             out_last
);
    import cbps_pkg::*;

    localparam int NUM_BITS = DEN_BITS + COORD_BITS;
    localparam int ACC_BITS = NUM_BITS + 1;

    // One restoring-division step: returns {remainder, quotient shifter}.
    function automatic logic [DEN_BITS+NUM_BITS-1:0] div_step(
        input logic [DEN_BITS-1:0] rem,
        input logic [NUM_BITS-1:0] quo,
        input logic [DEN_BITS-1:0] den
    );
        logic [DEN_BITS:0]   sh;
        logic [DEN_BITS+1:0] diff;
        sh   = {rem, quo[NUM_BITS-1]};
        diff = {1'b0, sh} - {2'b00, den};
        if (diff[DEN_BITS+1])
        begin
            return {sh[DEN_BITS-1:0], quo[NUM_BITS-2:0], 1'b0};
        end
        return {diff[DEN_BITS-1:0], quo[NUM_BITS-2:0], 1'b1};
    endfunction

    logic signed [COORD_BITS-1:0] x_reg [4];
    logic signed [COORD_BITS-1:0] y_reg [4];
    logic [CNT_BITS-1:0]          s_reg, idx_reg;
    logic [2*CNT_BITS-1:0]        den_sq_reg, a_sq_reg, i_sq_reg;
    logic [DEN_BITS-1:0]          den_reg;
    logic [DEN_BITS-1:0]          w_reg [4];
    logic signed [ACC_BITS-1:0]   prod_x_reg, prod_y_reg, acc_x_reg, acc_y_reg;
    logic [DEN_BITS-1:0]          rem_x_reg, rem_y_reg;
    logic [NUM_BITS-1:0]          quo_x_reg, quo_y_reg;
    logic                         neg_x_reg, neg_y_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                         out_last_reg, out_valid_reg;

    logic [CNT_BITS-1:0]          s_next, a_val;
    logic [DEN_BITS+1:0]          w1_full, w2_full, w1_3, w2_3;
    logic [DEN_BITS-1:0]          w0_val, w3_val;
    logic signed [DEN_BITS:0]     op_w;
    logic signed [ACC_BITS-1:0]   prod_x, prod_y, neg_acc_x, neg_acc_y;
    logic [NUM_BITS-1:0]          mag_x, mag_y;
    logic [DEN_BITS+NUM_BITS-1:0] step_x, step_y;
    logic [COORD_BITS-1:0]        q_x, q_y, res_x, res_y;

    always_comb
    begin
        // clamp the requested count
        if (int'(in_cnt) > MAX_STEPS)
        begin
            s_next = CNT_BITS'(MAX_STEPS);
        end
        else
        begin
            s_next = in_cnt;
        end

        a_val   = s_reg - idx_reg;
        w0_val  = a_sq_reg * a_val;
        w3_val  = i_sq_reg * idx_reg;
        w1_full = a_sq_reg * idx_reg;
        w2_full = i_sq_reg * a_val;
        w1_3    = w1_full + {w1_full[DEN_BITS:0], 1'b0};
        w2_3    = w2_full + {w2_full[DEN_BITS:0], 1'b0};

        op_w    = {1'b0, w_reg[cmd.sel]};
        prod_x  = op_w * x_reg[cmd.sel];
        prod_y  = op_w * y_reg[cmd.sel];

        neg_acc_x = -acc_x_reg;
        neg_acc_y = -acc_y_reg;
        mag_x = acc_x_reg[ACC_BITS-1] ? neg_acc_x[NUM_BITS-1:0] : acc_x_reg[NUM_BITS-1:0];
        mag_y = acc_y_reg[ACC_BITS-1] ? neg_acc_y[NUM_BITS-1:0] : acc_y_reg[NUM_BITS-1:0];

        step_x = div_step(rem_x_reg, quo_x_reg, den_reg);
        step_y = div_step(rem_y_reg, quo_y_reg, den_reg);

        // truncate toward zero: divide magnitudes, then restore the sign
        q_x   = quo_x_reg[COORD_BITS-1:0];
        q_y   = quo_y_reg[COORD_BITS-1:0];
        res_x = neg_x_reg ? (~q_x + 1'b1) : q_x;
        res_y = neg_y_reg ? (~q_y + 1'b1) : q_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                s_reg   <= s_next;
                idx_reg <= CNT_BITS'(1);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        if (cmd.den_sq)
        begin
            den_sq_reg <= s_reg * s_reg;
        end
        if (cmd.den_cube)
        begin
            den_reg <= den_sq_reg * s_reg;
        end
        if (cmd.wgt_sq)
        begin
            a_sq_reg <= a_val * a_val;
            i_sq_reg <= idx_reg * idx_reg;
        end
        if (cmd.wgt_cube)
        begin
            w_reg[0] <= w0_val;
            w_reg[1] <= w1_3[DEN_BITS-1:0];
            w_reg[2] <= w2_3[DEN_BITS-1:0];
            w_reg[3] <= w3_val;
        end
        if (cmd.acc_clr)
        begin
            prod_x_reg <= '0;
            prod_y_reg <= '0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
        end
        else
        begin
            if (cmd.mul_en)
            begin
                prod_x_reg <= prod_x;
                prod_y_reg <= prod_y;
            end
            if (cmd.add_en)
            begin
                acc_x_reg <= acc_x_reg + prod_x_reg;
                acc_y_reg <= acc_y_reg + prod_y_reg;
            end
        end
        if (cmd.div_init)
        begin
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            quo_x_reg <= mag_x;
            quo_y_reg <= mag_y;
            neg_x_reg <= acc_x_reg[ACC_BITS-1];
            neg_y_reg <= acc_y_reg[ACC_BITS-1];
        end
        else if (cmd.div_step)
        begin
            {rem_x_reg, quo_x_reg} <= step_x;
            {rem_y_reg, quo_y_reg} <= step_y;
        end
        if (cmd.out_load)
        begin
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_last_reg <= (idx_reg == s_reg);
        end
    end

    assign stat.s_zero   = (s_reg == '0);
    assign stat.last     = (idx_reg == s_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: design/cubic_bezier_point_sampler.sv
// Top level of the cubic Bezier point sampler: stream ports, field packing,
// controller and datapath. Depends on cbps_pkg, cbps_ctrl and cbps_dpath.
//
//  channel  direction  transaction carries
//  -------  ---------  ----------------------------------------------------
//  s_*      in         four control points and a step count (one curve)
//  m_*      out        one sampled point; tlast marks the final point
//
// Each point runs the weight, MAC, divide and output states in turn. The
// bit-serial divider takes one quotient bit per cycle over 21 + COORD_BITS
// bits; x and y run in parallel lanes. A zero count returns to idle from the
// s*s step with no output transaction. Reset clears the controller, the clamped
// step count, the point index and output valid; nothing else needs clearing.
// A stalled output holds the point; the controller waits in its output state,
// and s_tready rises again once the last point has moved to the output register.
module cubic_bezier_point_sampler #(
    parameter int MAX_STEPS  = cbps_pkg::MAX_STEPS_DEF,
    parameter int COORD_BITS = cbps_pkg::COORD_BITS_DEF,
    localparam int IN_W      = 8 * COORD_BITS + cbps_pkg::CNT_BITS,
    localparam int IN_DW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_DW    = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    // step_count, zero fill
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // point_x, point_y, zero fill
    output logic [OUT_DW-1:0] m_tdata,
    // last_point
    output logic              m_tlast
);
    import cbps_pkg::*;

    cmd_t                         cmd;
    stat_t                        stat;
    logic signed [COORD_BITS-1:0] in_x [4];
    logic signed [COORD_BITS-1:0] in_y [4];
    logic [CNT_BITS-1:0]          in_cnt;
    logic signed [COORD_BITS-1:0] point_x, point_y;

    // Unpack the control points: even fields are x, odd fields are y.
    for (genvar j = 0; j < 4; j++)
    begin : g_unpack
        assign in_x[j] = s_tdata[(2*j)*COORD_BITS +: COORD_BITS];
        assign in_y[j] = s_tdata[(2*j+1)*COORD_BITS +: COORD_BITS];
    end
    assign in_cnt = s_tdata[8*COORD_BITS +: CNT_BITS];

    cbps_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cbps_dpath #(
        .MAX_STEPS  (MAX_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_cnt    (in_cnt),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_x     (point_x),
        .out_y     (point_y),
        .out_last  (m_tlast)
    );

    // Pack the point, zero fill on top.
    assign m_tdata = OUT_DW'({point_y, point_x});

    // Never overwrite a point that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // An accepted curve keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after a transaction");

    // Never advance past the final point of a run.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_inc |-> !stat.last)
        else $error("point index advanced past the step count");

    // The final point leaves the output register only with tlast.
    a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && stat.last) |=> (m_tvalid && m_tlast))
        else $error("final point loaded without tlast");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for cubic_bezier_point_sampler: directed curves from a
// table, then random curves, each point checked against an integer predictor.
// Depends only on the RTL top level cubic_bezier_point_sampler.
module testbench;

    localparam int COORD_W    = 16;
    localparam int STEP_LIMIT = 64;
    localparam int RANDOM_CURVES = 156;
    // Long enough for one curve at the largest count to run after the last
    // expected point, so a stray extra point would still be caught.
    localparam int DRAIN_CYCLES = 3000;
    localparam int HOLD_CYCLES  = 700;

    // Control points and count, first field in the lowest bits, as on s_tdata.
    typedef struct packed {
        logic [6:0]                steps;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] c2_y;
        logic signed [COORD_W-1:0] c2_x;
        logic signed [COORD_W-1:0] c1_y;
        logic signed [COORD_W-1:0] c1_x;
        logic signed [COORD_W-1:0] st_y;
        logic signed [COORD_W-1:0] st_x;
    } curve_t;

    typedef struct packed {
        logic                      is_last;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // One directed row; where typed is set, every point of the curve must equal
    // (tx, ty), which holds for single-step and flat curves.
    typedef struct packed {
        curve_t                    crv;
        logic                      typed;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;    // st_x, st_y, c1_x, c1_y, c2_x, c2_y, end_x, end_y, steps, 0
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;    // point_x, point_y
    logic         m_tlast;    // last_point

    point_t pending_points[$];
    row_t   directed_rows[$];

    int  mismatches = 0;
    int  curves_accepted = 0;
    int  points_checked = 0;
    int  zero_curves = 0;
    int  clamped_curves = 0;
    bit  steady = 1'b0;       // suppress idling on both sides while set

    cubic_bezier_point_sampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run; sized for every curve at the largest count, several times over.
    initial
    begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

    // Exact cubic blend of one coordinate at t = i/s, quotient truncated toward zero.
    function automatic logic signed [COORD_W-1:0] bezier_blend(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint s, input longint i);
        longint a;
        longint num;
        longint quo;
        a   = s - i;
        num = a * a * a * p0 + 3 * a * a * i * p1 + 3 * a * i * i * p2 + i * i * i * p3;
        quo = num / (s * s * s);
        return quo[COORD_W-1:0];
    endfunction

    // Queue every point the block owes for one accepted curve.
    function automatic void predict_curve(input curve_t c, input logic typed,
                                          input logic signed [COORD_W-1:0] tx,
                                          input logic signed [COORD_W-1:0] ty);
        int     s;
        point_t p;
        s = (c.steps > STEP_LIMIT) ? STEP_LIMIT : int'(c.steps);
        if (s == 0)
            zero_curves++;
        if (c.steps > STEP_LIMIT)
            clamped_curves++;
        for (int i = 1; i <= s; i++)
        begin
            if (typed)
            begin
                p.x = tx;
                p.y = ty;
            end
            else
            begin
                p.x = bezier_blend($signed(c.st_x), $signed(c.c1_x), $signed(c.c2_x),
                                   $signed(c.end_x), s, i);
                p.y = bezier_blend($signed(c.st_y), $signed(c.c1_y), $signed(c.c2_y),
                                   $signed(c.end_y), s, i);
            end
            p.is_last = (i == s);
            pending_points.push_back(p);
        end
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [6:0] random_steps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7)
            return 7'd0;
        if (r < 14)
            return 7'($urandom_range(STEP_LIMIT, 127));
        if (r < 24)
            return 7'($urandom_range(13, STEP_LIMIT - 1));
        return 7'($urandom_range(1, 12));
    endfunction

    task automatic add_row(input int sx, input int sy, input int ax, input int ay,
                           input int bx, input int by, input int ex, input int ey,
                           input int steps, input bit typed, input int tx, input int ty);
        row_t r;
        r.crv.st_x  = COORD_W'(sx);
        r.crv.st_y  = COORD_W'(sy);
        r.crv.c1_x  = COORD_W'(ax);
        r.crv.c1_y  = COORD_W'(ay);
        r.crv.c2_x  = COORD_W'(bx);
        r.crv.c2_y  = COORD_W'(by);
        r.crv.end_x = COORD_W'(ex);
        r.crv.end_y = COORD_W'(ey);
        r.crv.steps = 7'(steps);
        r.typed     = typed;
        r.tx        = COORD_W'(tx);
        r.ty        = COORD_W'(ty);
        directed_rows.push_back(r);
    endtask

    // Offer one curve, with random idle cycles ahead of it, and hold it until the
    // input transaction completes; valid stays high into the next curve.
    task automatic send_curve(input curve_t c, input logic typed,
                              input logic signed [COORD_W-1:0] tx,
                              input logic signed [COORD_W-1:0] ty);
        while (!steady && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c};
        do
            @(posedge clk);
        while (!s_tready);
        curves_accepted++;
        predict_curve(c, typed, tx, ty);
    endtask

    // Output side: check each transaction, then pick the next ready value.
    // Once, hold ready low long enough for the block to back up to its input.
    initial
    begin : point_sink
        int  hold_left;
        bit  held_once;
        point_t got;
        point_t want;
        hold_left = 0;
        held_once = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.x       = m_tdata[15:0];
                got.y       = m_tdata[31:16];
                got.is_last = m_tlast;
                points_checked++;
                if (pending_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no point, got x=%0d y=%0d last=%0b",
                             $time, got.x, got.y, got.is_last);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x)
                    begin
                        mismatches++;
                        $display("%0t: point_x expected %0d, got %0d", $time, want.x, got.x);
                    end
                    if (got.y !== want.y)
                    begin
                        mismatches++;
                        $display("%0t: point_y expected %0d, got %0d", $time, want.y, got.y);
                    end
                    if (got.is_last !== want.is_last)
                    begin
                        mismatches++;
                        $display("%0t: last_point expected %0b, got %0b",
                                 $time, want.is_last, got.is_last);
                    end
                end
            end
            if (!held_once && curves_accepted >= 40)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 14);
        end
    end

    initial
    begin : curve_source
        curve_t c;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        // Directed table: sx, sy, c1x, c1y, c2x, c2y, ex, ey, steps, typed, tx, ty
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);                  // zero count
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                5, 1, 32767, 32767);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                5, 1, -32768, -32768);
        add_row(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767,
                1, 1, -32768, 32767);                                  // one step lands on end
        add_row(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
                1, 1, 32767, -32768);
        add_row(1000, -2000, 32767, 32767, -32768, -32768, -1000, 2000, 64, 0, 0, 0);
        add_row(1000, -2000, 32767, 32767, -32768, -32768, -1000, 2000, 65, 0, 0, 0);
        add_row(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768,
                127, 0, 0, 0);                                         // saturates to limit
        add_row(-1, 1, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0);                  // truncation toward zero
        add_row(12345, -4321, -32768, 0, 32767, -1, 0, 32767, 0, 1, 0, 0);
        add_row(100, 200, 300, 400, 500, 600, 700, 800, 2, 0, 0, 0);
        add_row(-7, -7, -7, -7, -7, -7, -7, -7, 7, 1, -7, -7);
        add_row(0, 0, 32767, -32768, 32767, -32768, 0, 0, 63, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_curve(directed_rows[k].crv, directed_rows[k].typed,
                       directed_rows[k].tx, directed_rows[k].ty);

        for (int n = 0; n < RANDOM_CURVES; n++)
        begin
            steady = (n >= 60 && n < 100);
            c.st_x  = random_coord();
            c.st_y  = random_coord();
            c.c1_x  = random_coord();
            c.c1_y  = random_coord();
            c.c2_x  = random_coord();
            c.c2_y  = random_coord();
            c.end_x = random_coord();
            c.end_y = random_coord();
            c.steps = random_steps();
            send_curve(c, 1'b0, '0, '0);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d curves (%0d with zero count, %0d clamped to the step limit),",
                 curves_accepted, zero_curves, clamped_curves);
        $display("checked %0d sampled points with random gaps and one long output stall.",
                 points_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
